// ===== hdl/tnks_pkg.sv =====
package tnks_pkg;

  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned IDX_W       = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned KEY_W       = 24;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_LOAD,
    CMD_QUERY
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] size;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } eng_state_e;

endpackage

// ===== hdl/threshold_nearest_key_search.sv =====
// A query is scanned after it leaves the queue, one entry read per cycle; on an
// empty table it goes straight to its result. Clears and loads are done in the
// engine after the queue. The engine takes the next command from the queue only
// once the result of the previous query has been placed in its output register.
// Reset: asynchronous, active low; empties the queue and the table count.
module threshold_nearest_key_search (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // entry_id, entry_size, wanted_id, least_size
  input  logic [4*tnks_pkg::KEY_W-1:0] s_axis_tdata,
  // op
  input  logic [1:0]                   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // best_id
  output logic [tnks_pkg::KEY_W-1:0]   m_axis_tdata,
  // found
  output logic                         m_axis_tuser
);

  tnks_pkg::cmd_t push_cmd, pop_cmd;
  logic           q_full, q_push, q_valid, q_pop;

  tnks_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_op_i    (s_axis_tuser),
    .s_data_i  (s_axis_tdata),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_cmd_o   (push_cmd)
  );

  tnks_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (pop_cmd)
  );

  tnks_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (pop_cmd),
    .cmd_pop_o   (q_pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_found_o   (m_axis_tuser),
    .m_best_id_o (m_axis_tdata)
  );

endmodule

// ===== hdl/tnks_front.sv =====
module tnks_front (
  input  logic                       s_valid_i,
  output logic                       s_ready_o,
  input  logic [1:0]                 s_op_i,
  input  logic [4*tnks_pkg::KEY_W-1:0] s_data_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output tnks_pkg::cmd_t             q_cmd_o
);

  logic is_cmd;

  always_comb begin
    is_cmd         = 1'b1;
    q_cmd_o.kind   = tnks_pkg::CMD_CLEAR;
    q_cmd_o.key    = s_data_i[tnks_pkg::KEY_W-1:0];
    q_cmd_o.size   = s_data_i[2*tnks_pkg::KEY_W-1:tnks_pkg::KEY_W];
    case (s_op_i)
      tnks_pkg::OP_CLEAR: begin
        q_cmd_o.kind = tnks_pkg::CMD_CLEAR;
      end
      tnks_pkg::OP_LOAD: begin
        q_cmd_o.kind = tnks_pkg::CMD_LOAD;
      end
      tnks_pkg::OP_QUERY: begin
        q_cmd_o.kind = tnks_pkg::CMD_QUERY;
        q_cmd_o.key  = s_data_i[3*tnks_pkg::KEY_W-1:2*tnks_pkg::KEY_W];
        q_cmd_o.size = s_data_i[4*tnks_pkg::KEY_W-1:3*tnks_pkg::KEY_W];
      end
      default: begin
        // drop unused op codes
        is_cmd = 1'b0;
      end
    endcase
  end

  assign s_ready_o = !q_full_i;
  assign q_push_o  = s_valid_i && !q_full_i && is_cmd;

endmodule

// ===== hdl/tnks_queue.sv =====
module tnks_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tnks_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tnks_pkg::cmd_t pop_cmd_o
);

  tnks_pkg::cmd_t                  slot_q [tnks_pkg::QUEUE_DEPTH];
  logic [tnks_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [tnks_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [tnks_pkg::QCNT_W-1:0]     fill_q, fill_d;
  logic                            do_push, do_pop;

  assign full_o    = (fill_q == tnks_pkg::QCNT_W'(tnks_pkg::QUEUE_DEPTH));
  assign valid_o   = (fill_q != '0);
  assign pop_cmd_o = slot_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (!do_push && do_pop) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== hdl/tnks_engine.sv =====
module tnks_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  tnks_pkg::cmd_t             cmd_i,
  output logic                       cmd_pop_o,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic                       m_found_o,
  output logic [tnks_pkg::KEY_W-1:0] m_best_id_o
);

  logic [2*tnks_pkg::KEY_W-1:0] mem [tnks_pkg::MAX_ENTRIES];

  tnks_pkg::eng_state_e         state_q, state_d;
  logic [tnks_pkg::CNT_W-1:0]   count_q, count_d;
  logic [tnks_pkg::IDX_W-1:0]   addr_q;
  logic [tnks_pkg::KEY_W-1:0]   want_q, least_q;
  logic [2*tnks_pkg::KEY_W-1:0] rd_data_q;
  logic                         rd_v_q;
  logic                         cmp_v_q;
  logic [tnks_pkg::KEY_W-1:0]   cmp_id_q, cmp_dist_q;
  logic                         have_q;
  logic [tnks_pkg::KEY_W-1:0]   best_id_q, best_dist_q;
  logic                         out_valid_q;
  logic                         out_found_q;
  logic [tnks_pkg::KEY_W-1:0]   out_id_q;

  logic                         out_free, pop, start, rd_en, finish, last_issue, room, do_load;
  logic [tnks_pkg::KEY_W-1:0]   rd_id, rd_size, rd_dist;
  logic                         better;

  assign out_free   = !out_valid_q || m_ready_i;
  assign last_issue = (tnks_pkg::CNT_W'(addr_q) + 1'b1) == count_q;
  assign room       = count_q < tnks_pkg::CNT_W'(tnks_pkg::MAX_ENTRIES);
  assign rd_id      = rd_data_q[tnks_pkg::KEY_W-1:0];
  assign rd_size    = rd_data_q[2*tnks_pkg::KEY_W-1:tnks_pkg::KEY_W];
  assign rd_dist    = (rd_id >= want_q) ? rd_id - want_q : want_q - rd_id;
  assign better     = !have_q || (cmp_dist_q < best_dist_q) ||
                      ((cmp_dist_q == best_dist_q) && (cmp_id_q < best_id_q));

  always_comb begin
    state_d = state_q;
    case (state_q)
      tnks_pkg::ST_IDLE: begin
        if (cmd_valid_i && cmd_i.kind == tnks_pkg::CMD_QUERY) begin
          state_d = (count_q == '0) ? tnks_pkg::ST_DONE : tnks_pkg::ST_SCAN;
        end
      end
      tnks_pkg::ST_SCAN: begin
        if (last_issue) begin
          state_d = tnks_pkg::ST_DRAIN;
        end
      end
      tnks_pkg::ST_DRAIN: begin
        if (!rd_v_q && !cmp_v_q) begin
          state_d = tnks_pkg::ST_DONE;
        end
      end
      tnks_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = tnks_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tnks_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    pop    = 1'b0;
    rd_en  = 1'b0;
    finish = 1'b0;
    case (state_q)
      tnks_pkg::ST_IDLE: begin
        pop = cmd_valid_i;
      end
      tnks_pkg::ST_SCAN: begin
        rd_en = 1'b1;
      end
      tnks_pkg::ST_DONE: begin
        finish = out_free;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  assign cmd_pop_o = pop;
  assign start     = pop && cmd_i.kind == tnks_pkg::CMD_QUERY;
  assign do_load   = pop && cmd_i.kind == tnks_pkg::CMD_LOAD && room;

  always_comb begin
    count_d = count_q;
    if (pop && cmd_i.kind == tnks_pkg::CMD_CLEAR) begin
      count_d = '0;
    end else if (do_load) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tnks_pkg::ST_IDLE;
      count_q     <= '0;
      rd_v_q      <= 1'b0;
      cmp_v_q     <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rd_v_q  <= rd_en;
      cmp_v_q <= rd_v_q && (rd_size >= least_q);
      if (start) begin
        have_q <= 1'b0;
      end else if (cmp_v_q && better) begin
        have_q <= 1'b1;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      mem[count_q[tnks_pkg::IDX_W-1:0]] <= {cmd_i.size, cmd_i.key};
    end
    if (rd_en) begin
      rd_data_q <= mem[addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      want_q  <= cmd_i.key;
      least_q <= cmd_i.size;
      addr_q  <= '0;
    end else if (rd_en) begin
      addr_q <= addr_q + 1'b1;
    end
    cmp_id_q   <= rd_id;
    cmp_dist_q <= rd_dist;
    if (cmp_v_q && better) begin
      best_id_q   <= cmp_id_q;
      best_dist_q <= cmp_dist_q;
    end
    if (finish) begin
      out_found_q <= have_q;
      out_id_q    <= have_q ? best_id_q : '0;
    end
  end

  assign m_valid_o   = out_valid_q;
  assign m_found_o   = out_found_q;
  assign m_best_id_o = out_id_q;

endmodule
